>>> rtl/lhfe_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhfe_pkg
// Types and constants shared by the log and heartbeat frame encoder.
// ----------------------------------------------------------------------------
package lhfe_pkg;

   typedef struct packed {
      logic       req_type;
      logic [7:0] payload_byte;
      logic [7:0] payload_len;
   } req_beat_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       frame_end;
      logic       run_last;
   } rsp_beat_type;

   // byte run caused by one input beat
   typedef struct packed {
      logic        has_hdr;
      logic        has_byte;
      logic        has_csum;
      logic        has_beat;
      logic [7:0]  len;
      logic [7:0]  data;
      logic [15:0] sum;
      logic [31:0] count;
      logic [15:0] beat_sum;
   } job_type;

   localparam logic [7:0] SYNC_A   = 8'h64;
   localparam logic [7:0] SYNC_B   = 8'h62;
   localparam logic [7:0] CMD_LOG  = 8'h00;
   localparam logic [7:0] CMD_BEAT = 8'hFF;
   localparam logic [7:0] BEAT_LEN = 8'd4;
   localparam int         FRAME_OVERHEAD = 8;

   localparam int POS_W = 5;
   localparam logic [POS_W-1:0] POS_SYNC_A      = 5'd0;
   localparam logic [POS_W-1:0] POS_SYNC_B      = 5'd1;
   localparam logic [POS_W-1:0] POS_CMD         = 5'd2;
   localparam logic [POS_W-1:0] POS_ZERO        = 5'd3;
   localparam logic [POS_W-1:0] POS_LEN_LO      = 5'd4;
   localparam logic [POS_W-1:0] POS_LEN_HI      = 5'd5;
   localparam logic [POS_W-1:0] POS_DATA        = 5'd6;
   localparam logic [POS_W-1:0] POS_SUM_LO      = 5'd7;
   localparam logic [POS_W-1:0] POS_SUM_HI      = 5'd8;
   localparam logic [POS_W-1:0] POS_BEAT_SYNC_A = 5'd9;
   localparam logic [POS_W-1:0] POS_BEAT_SYNC_B = 5'd10;
   localparam logic [POS_W-1:0] POS_BEAT_CMD    = 5'd11;
   localparam logic [POS_W-1:0] POS_BEAT_ZERO   = 5'd12;
   localparam logic [POS_W-1:0] POS_BEAT_LEN_LO = 5'd13;
   localparam logic [POS_W-1:0] POS_BEAT_LEN_HI = 5'd14;
   localparam logic [POS_W-1:0] POS_COUNT_0     = 5'd15;
   localparam logic [POS_W-1:0] POS_COUNT_1     = 5'd16;
   localparam logic [POS_W-1:0] POS_COUNT_2     = 5'd17;
   localparam logic [POS_W-1:0] POS_COUNT_3     = 5'd18;
   localparam logic [POS_W-1:0] POS_BEAT_SUM_LO = 5'd19;
   localparam logic [POS_W-1:0] POS_BEAT_SUM_HI = 5'd20;

endpackage
`default_nettype wire

>>> rtl/lhfe_emit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lhfe_emit
// Holds one byte run and walks it out one byte per cycle into the
// registered result stage, while that stage is not held by rsp_stall.
// ----------------------------------------------------------------------------
module lhfe_emit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              job_push,
   input  wire lhfe_pkg::job_type job_in,
   output logic                   job_ready,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output lhfe_pkg::rsp_beat_type rsp_payload
);

   logic                         job_valid_ff, job_valid_in;
   lhfe_pkg::job_type            job_ff, job_next;
   logic [lhfe_pkg::POS_W-1:0]   pos_ff, pos_in, pos_first, pos_next;
   logic                         rsp_valid_ff, rsp_valid_in;
   lhfe_pkg::rsp_beat_type       rsp_ff, rsp_in;
   logic                         load, last;
   logic [7:0]                   cur_byte;
   logic                         cur_end;

   assign load      = job_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign job_ready = !job_valid_ff || (load && last);

   always_comb begin
      if (job_in.has_hdr) begin
         pos_first = lhfe_pkg::POS_SYNC_A;
      end else if (job_in.has_byte) begin
         pos_first = lhfe_pkg::POS_DATA;
      end else if (job_in.has_csum) begin
         pos_first = lhfe_pkg::POS_SUM_LO;
      end else begin
         pos_first = lhfe_pkg::POS_BEAT_SYNC_A;
      end
   end

   always_comb begin
      pos_next = pos_ff + 1'b1;
      last     = 1'b0;
      case (pos_ff)
         lhfe_pkg::POS_LEN_HI: begin
            pos_next = lhfe_pkg::POS_DATA;
         end
         lhfe_pkg::POS_DATA: begin
            pos_next = job_ff.has_csum ? lhfe_pkg::POS_SUM_LO : lhfe_pkg::POS_BEAT_SYNC_A;
            last     = !job_ff.has_csum && !job_ff.has_beat;
         end
         lhfe_pkg::POS_SUM_HI: begin
            pos_next = lhfe_pkg::POS_BEAT_SYNC_A;
            last     = !job_ff.has_beat;
         end
         lhfe_pkg::POS_BEAT_SUM_HI: begin
            last = 1'b1;
         end
         default: begin
            pos_next = pos_ff + 1'b1;
         end
      endcase
   end

   always_comb begin
      cur_end = 1'b0;
      case (pos_ff)
         lhfe_pkg::POS_SYNC_A:      cur_byte = lhfe_pkg::SYNC_A;
         lhfe_pkg::POS_SYNC_B:      cur_byte = lhfe_pkg::SYNC_B;
         lhfe_pkg::POS_CMD:         cur_byte = lhfe_pkg::CMD_LOG;
         lhfe_pkg::POS_ZERO:        cur_byte = 8'h00;
         lhfe_pkg::POS_LEN_LO:      cur_byte = job_ff.len;
         lhfe_pkg::POS_LEN_HI:      cur_byte = 8'h00;
         lhfe_pkg::POS_DATA:        cur_byte = job_ff.data;
         lhfe_pkg::POS_SUM_LO:      cur_byte = job_ff.sum[7:0];
         lhfe_pkg::POS_SUM_HI: begin
            cur_byte = job_ff.sum[15:8];
            cur_end  = 1'b1;
         end
         lhfe_pkg::POS_BEAT_SYNC_A: cur_byte = lhfe_pkg::SYNC_A;
         lhfe_pkg::POS_BEAT_SYNC_B: cur_byte = lhfe_pkg::SYNC_B;
         lhfe_pkg::POS_BEAT_CMD:    cur_byte = lhfe_pkg::CMD_BEAT;
         lhfe_pkg::POS_BEAT_ZERO:   cur_byte = 8'h00;
         lhfe_pkg::POS_BEAT_LEN_LO: cur_byte = lhfe_pkg::BEAT_LEN;
         lhfe_pkg::POS_BEAT_LEN_HI: cur_byte = 8'h00;
         lhfe_pkg::POS_COUNT_0:     cur_byte = job_ff.count[7:0];
         lhfe_pkg::POS_COUNT_1:     cur_byte = job_ff.count[15:8];
         lhfe_pkg::POS_COUNT_2:     cur_byte = job_ff.count[23:16];
         lhfe_pkg::POS_COUNT_3:     cur_byte = job_ff.count[31:24];
         lhfe_pkg::POS_BEAT_SUM_LO: cur_byte = job_ff.beat_sum[7:0];
         lhfe_pkg::POS_BEAT_SUM_HI: begin
            cur_byte = job_ff.beat_sum[15:8];
            cur_end  = 1'b1;
         end
         default:                   cur_byte = 8'h00;
      endcase
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_next     = job_ff;
      pos_in       = pos_ff;
      if (job_push) begin
         job_valid_in = 1'b1;
         job_next     = job_in;
         pos_in       = pos_first;
      end else if (load && last) begin
         job_valid_in = 1'b0;
      end else if (load) begin
         pos_in = pos_next;
      end

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_byte    = cur_byte;
         rsp_in.frame_end   = cur_end;
         rsp_in.run_last    = last;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff <= job_next;
      pos_ff <= pos_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire

>>> rtl/log_heartbeat_frame_encoder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// log_heartbeat_frame_encoder
// Frames log payload bytes and heartbeat ticks into a byte stream with sync,
// command, length and 16-bit additive checksum.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// req      in   req_valid/stall    req_type, payload_byte, payload_len
// rsp      out  rsp_valid/stall    out_byte, frame_end, run_last
//
// each accepted input beat updates the frame state and hands its byte run to
// the byte walker, which sends the bytes one per cycle unless rsp_stall holds:
// 1 byte for a payload byte, 7 to 9 for a frame start, 12 for a heartbeat,
// up to 15 with a checksum and held heartbeat.
// a beat with no bytes leaves no run, but it still waits for the walker.
// reset is synchronous and clears the frame state and heartbeat counter.
// rsp_stall holds the result register; req_stall rises while a run is queued.
// ----------------------------------------------------------------------------
module log_heartbeat_frame_encoder #(
   parameter int MAX_FRAME_BYTES = 128
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lhfe_pkg::req_beat_type req_payload,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lhfe_pkg::rsp_beat_type      rsp_payload
);

   localparam int MaxLen = MAX_FRAME_BYTES - lhfe_pkg::FRAME_OVERHEAD;
   localparam logic [9:0] MaxLenW = 10'(MaxLen);

   logic        frame_open_ff, frame_open_in;
   logic        frame_dropping_ff, frame_dropping_in;
   logic [7:0]  bytes_seen_ff, bytes_seen_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [15:0] running_sum_ff, running_sum_in;
   logic [31:0] beat_count_ff, beat_count_in;
   logic        beat_pending_ff, beat_pending_in;

   logic              accept, job_ready, job_push;
   lhfe_pkg::job_type job;
   logic [7:0]        seen_inc;
   logic [15:0]       sum_add;
   logic [31:0]       count_snap;

   assign accept    = req_valid && !req_stall;
   assign req_stall = !job_ready;
   assign seen_inc  = bytes_seen_ff + 8'd1;
   assign sum_add   = running_sum_ff + {8'h00, req_payload.payload_byte};

   always_comb begin
      frame_open_in     = frame_open_ff;
      frame_dropping_in = frame_dropping_ff;
      bytes_seen_in     = bytes_seen_ff;
      frame_length_in   = frame_length_ff;
      running_sum_in    = running_sum_ff;
      beat_count_in     = beat_count_ff;
      beat_pending_in   = beat_pending_ff;
      count_snap        = beat_count_ff;

      job          = '0;
      job.len      = req_payload.payload_len;
      job.data     = req_payload.payload_byte;

      if (req_payload.req_type) begin
         beat_count_in = beat_count_ff + 32'd1;
         count_snap    = beat_count_in;
         if (frame_open_ff && !frame_dropping_ff) begin
            beat_pending_in = 1'b1;
         end else begin
            job.has_beat = 1'b1;
         end
      end else if (!frame_open_ff) begin
         if (req_payload.payload_len != 8'd0) begin
            frame_open_in   = 1'b1;
            frame_length_in = req_payload.payload_len;
            bytes_seen_in   = 8'd1;
            if ({2'b00, req_payload.payload_len} > MaxLenW) begin
               frame_dropping_in = 1'b1;
            end else begin
               job.has_hdr    = 1'b1;
               job.has_byte   = 1'b1;
               job.sum        = {8'h00, req_payload.payload_len} +
                                {8'h00, req_payload.payload_byte};
               running_sum_in = job.sum;
            end
            if (req_payload.payload_len == 8'd1) begin
               job.has_csum      = !frame_dropping_in;
               frame_open_in     = 1'b0;
               frame_dropping_in = 1'b0;
               bytes_seen_in     = 8'd0;
               frame_length_in   = 8'd0;
               running_sum_in    = 16'd0;
            end
         end
      end else begin
         bytes_seen_in = seen_inc;
         if (!frame_dropping_ff) begin
            job.has_byte   = 1'b1;
            job.sum        = sum_add;
            running_sum_in = sum_add;
         end
         if (seen_inc == frame_length_ff) begin
            job.has_csum      = !frame_dropping_ff;
            frame_open_in     = 1'b0;
            frame_dropping_in = 1'b0;
            bytes_seen_in     = 8'd0;
            frame_length_in   = 8'd0;
            running_sum_in    = 16'd0;
            if (beat_pending_ff) begin
               beat_pending_in = 1'b0;
               job.has_beat    = 1'b1;
            end
         end
      end

      job.count    = count_snap;
      job.beat_sum = 16'(lhfe_pkg::CMD_BEAT) + 16'(lhfe_pkg::BEAT_LEN) +
                     {8'h00, count_snap[7:0]} + {8'h00, count_snap[15:8]} +
                     {8'h00, count_snap[23:16]} + {8'h00, count_snap[31:24]};
   end

   assign job_push = accept && (job.has_hdr || job.has_byte || job.has_csum || job.has_beat);

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_open_ff     <= 1'b0;
         frame_dropping_ff <= 1'b0;
         bytes_seen_ff     <= 8'd0;
         frame_length_ff   <= 8'd0;
         running_sum_ff    <= 16'd0;
         beat_count_ff     <= 32'd0;
         beat_pending_ff   <= 1'b0;
      end else if (accept) begin
         frame_open_ff     <= frame_open_in;
         frame_dropping_ff <= frame_dropping_in;
         bytes_seen_ff     <= bytes_seen_in;
         frame_length_ff   <= frame_length_in;
         running_sum_ff    <= running_sum_in;
         beat_count_ff     <= beat_count_in;
         beat_pending_ff   <= beat_pending_in;
      end
   end

   lhfe_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .job_push    (job_push),
      .job_in      (job),
      .job_ready   (job_ready),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

`ifndef ASSERT_OFF
   a_pending_in_open: assert property (@(posedge clock) disable iff (reset)
      beat_pending_ff |-> (frame_open_ff && !frame_dropping_ff))
      else $error("held heartbeat without an open sent frame");

   a_closed_clear: assert property (@(posedge clock) disable iff (reset)
      !frame_open_ff |-> (bytes_seen_ff == 8'd0 && running_sum_ff == 16'd0))
      else $error("closed frame left counters behind");

   a_open_count: assert property (@(posedge clock) disable iff (reset)
      frame_open_ff |-> (bytes_seen_ff < frame_length_ff && bytes_seen_ff != 8'd0))
      else $error("open frame byte count out of range");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_payload)))
      else $error("stalled output beat changed");
`endif

endmodule
`default_nettype wire
